### design/mspwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspwm_pkg: shared constants and types for the multichannel PWM generator
// Command and mode codes, field widths and the word types passed between
// the top level and the channel core.
// ----------------------------------------------------------------------------
package mspwm_pkg;

	// Sizes
	localparam int CHANNELS     = 16;
	localparam int PERIOD_TICKS = 100;
	localparam int CH_W         = $clog2(CHANNELS);
	localparam int CNT_W        = $clog2(CHANNELS + 1);
	localparam int PHASE_W      = 7;
	localparam int DUTY_W       = 8;
	localparam int ADUTY_W      = 7;
	localparam int CMD_W        = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	// Phase counter codes
	localparam logic [PHASE_W-1:0] PHASE_IDLE = {PHASE_W{1'b1}};
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PERIOD_TICKS - 1);

	// Command codes
	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_EN_ALL  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DIS_ALL = 3'd5;

	// Channel mode codes
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_RUN   = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;
	localparam logic [1:0] MODE_OFF   = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 2'd1;

	// One command word
	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [CH_W-1:0]   channel;
		logic [DUTY_W-1:0] duty_value;
	} cmd_word_t;

	// Configuration seen by the core
	typedef struct packed {
		logic [CNT_W-1:0]    channels_in_use;
		logic [CHANNELS-1:0] polarity_mask;
	} cfg_word_t;

	// Result of one step
	typedef struct packed {
		logic [CHANNELS-1:0] pin_levels;
		logic [PHASE_W-1:0]  phase;
	} res_word_t;

endpackage

### design/mspwm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspwm interfaces: command, result and configuration channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mspwm_cmd_if import mspwm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [CH_W-1:0]     channel;
	logic [DUTY_W-1:0]   duty_value;

	modport source (output valid, command, channel, duty_value, input ready);
	modport sink   (input valid, command, channel, duty_value, output ready);
endinterface

interface mspwm_res_if import mspwm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CHANNELS-1:0] pin_levels;
	logic [PHASE_W-1:0]  phase;

	modport source (output valid, pin_levels, phase, input ready);
	modport sink   (input valid, pin_levels, phase, output ready);
endinterface

interface mspwm_cfg_if import mspwm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, reg_index, data, input ready);
	modport sink   (input valid, reg_index, data, output ready);
endinterface

### design/mspwm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspwm_core: channel state and single-pass command update
// Holds phase, per-channel mode, active and shadow duty and pin levels;
// applies one command word per step and presents the resulting word.
// ----------------------------------------------------------------------------
module mspwm_core import mspwm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  cmd_word_t cmd_word,
	input  cfg_word_t cfg_word,
	output res_word_t res_word
);

	logic [PHASE_W-1:0]  phase_q;
	logic [1:0]          mode_q    [CHANNELS];
	logic [ADUTY_W-1:0]  active_q  [CHANNELS];
	logic [ADUTY_W-1:0]  pending_q [CHANNELS];
	logic [CHANNELS-1:0] levels_q;

	logic [PHASE_W-1:0]  phase_d;
	logic [1:0]          mode_d    [CHANNELS];
	logic [ADUTY_W-1:0]  active_d  [CHANNELS];
	logic [ADUTY_W-1:0]  pending_d [CHANNELS];
	logic [CHANNELS-1:0] levels_d;

	logic [CNT_W-1:0]    used;
	logic [PHASE_W-1:0]  phase_inc;
	logic                addressed;
	logic                duty_ok;

	// Clamp channel count and decode shared conditions
	always_comb begin
		used = (cfg_word.channels_in_use > CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS)
			: cfg_word.channels_in_use;
		phase_inc = phase_q + PHASE_W'(1);
		addressed = {1'b0, cmd_word.channel} < used;
		duty_ok = (cmd_word.duty_value >= DUTY_W'(1))
			&& (cmd_word.duty_value <= DUTY_W'(PERIOD_TICKS));
	end

	// Advance phase on a tick; go to idle in place of the last tick, then wrap to zero
	always_comb begin
		phase_d = phase_q;
		if (cmd_word.command == CMD_TICK) begin
			phase_d = (phase_inc == PHASE_LAST) ? PHASE_IDLE : phase_inc;
		end
	end

	// Per-channel next state
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			mode_d[i]    = mode_q[i];
			active_d[i]  = active_q[i];
			pending_d[i] = pending_q[i];
			levels_d[i]  = levels_q[i];
			case (cmd_word.command)
				CMD_TICK: begin
					if (CNT_W'(i) < used) begin
						case (mode_q[i])
							MODE_START: begin
								active_d[i] = pending_q[i];
								levels_d[i] = ~cfg_word.polarity_mask[i];
								mode_d[i]   = MODE_RUN;
							end
							MODE_RUN: begin
								if (phase_inc == active_q[i])
									levels_d[i] = cfg_word.polarity_mask[i];
								if (phase_inc == PHASE_LAST)
									mode_d[i] = MODE_START;
							end
							MODE_STOP: begin
								levels_d[i] = cfg_word.polarity_mask[i];
								mode_d[i]   = MODE_OFF;
							end
							default: ;
						endcase
					end
				end
				CMD_SET: begin
					if (addressed && cmd_word.channel == CH_W'(i)) begin
						if (duty_ok) begin
							pending_d[i] = cmd_word.duty_value[ADUTY_W-1:0];
						end else begin
							levels_d[i] = 1'b0;
							mode_d[i]   = MODE_STOP;
						end
					end
				end
				CMD_ENABLE: begin
					if (addressed && cmd_word.channel == CH_W'(i)) begin
						levels_d[i] = 1'b1;
						mode_d[i]   = MODE_START;
					end
				end
				CMD_DISABLE: begin
					if (addressed && cmd_word.channel == CH_W'(i)) begin
						levels_d[i] = 1'b0;
						mode_d[i]   = MODE_STOP;
					end
				end
				CMD_EN_ALL: begin
					if (CNT_W'(i) < used)
						mode_d[i] = MODE_START;
				end
				CMD_DIS_ALL: begin
					if (CNT_W'(i) < used)
						mode_d[i] = MODE_STOP;
				end
				default: ;
			endcase
		end
	end

	// Commit state on each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PHASE_IDLE;
			levels_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				mode_q[i]    <= MODE_OFF;
				active_q[i]  <= '0;
				pending_q[i] <= '0;
			end
		end else if (step) begin
			phase_q  <= phase_d;
			levels_q <= levels_d;
			for (int i = 0; i < CHANNELS; i++) begin
				mode_q[i]    <= mode_d[i];
				active_q[i]  <= active_d[i];
				pending_q[i] <= pending_d[i];
			end
		end
	end

	// Result word reflects the state after this step
	assign res_word.pin_levels = levels_d;
	assign res_word.phase      = (phase_d == PHASE_IDLE) ? PHASE_LAST : phase_d;

endmodule

### design/multichannel_soft_pwm_top.sv
`timescale 1ns / 1ps
// Path: a command accepted into the input register passes once through the channel
// update into the result register when that register is free or being read.
// Throughput: one command per cycle while results are taken; the result
// register parts the two sides so a new word is taken while one waits.
// Reset: all channels off, pins low, phase before zero, duty and config registers zero.
// ----------------------------------------------------------------------------
// multichannel_soft_pwm_top: multichannel PWM generator with shadow duty
// Input register, channel core and result register with valid/ready
// channels, plus the configuration registers.
// ----------------------------------------------------------------------------
module multichannel_soft_pwm_top import mspwm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	mspwm_cmd_if.sink    cmd,
	mspwm_res_if.source  res,
	mspwm_cfg_if.sink    cfg
);

	cmd_word_t cmd_s1;
	logic      valid_s1;
	logic      res_valid_q;
	res_word_t res_q;
	cfg_word_t cfg_q;
	res_word_t core_res;
	logic      advance;

	// Move the held word into the result register when it is free
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1.command    <= cmd.command;
			cmd_s1.channel    <= cmd.channel;
			cmd_s1.duty_value <= cmd.duty_value;
		end
	end

	// Configuration registers; writes to unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				CFG_CHANNELS: cfg_q.channels_in_use <= cfg.data[CNT_W-1:0];
				CFG_POLARITY: cfg_q.polarity_mask   <= cfg.data[CHANNELS-1:0];
				default: ;
			endcase
		end
	end

	mspwm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.cmd_word (cmd_s1),
		.cfg_word (cfg_q),
		.res_word (core_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= core_res;
	end

	assign res.valid      = res_valid_q;
	assign res.pin_levels = res_q.pin_levels;
	assign res.phase      = res_q.phase;

`ifndef SYNTH
	// A new result only follows a held command word
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a held command");

	// Phase shown never passes the last tick of the period
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.phase <= PHASE_LAST))
		else $error("phase out of range");

	// A full input stage with a stalled result blocks new commands
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid_q && !res.ready) |-> !cmd.ready)
		else $error("command taken while pipeline is stalled");
`endif

endmodule
